>>> hw/rtl/rdq_pkg.sv
// shared types and codes for the reversible deque
package rdq_pkg;

    // store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_BACK   = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_REVERSE    = 3'd4;

    // result status codes
    localparam logic [1:0] ST_POPPED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // input word
    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic has_result;
    } sts_t;

endpackage

>>> hw/rtl/rdq_ctrl.sv
// sequencing state machine for the reversible deque
module rdq_ctrl
    import rdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy,
    output logic done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = sts.has_result ? S_RESP : S_IDLE;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs
    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_RESP);
    assign ctl.load = (state_reg == S_IDLE) && start;
    assign ctl.exec = (state_reg == S_EXEC);

    // checks
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.exec))
        else $error("result strobe without a preceding execute cycle");
    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.exec)
        else $error("accepted word not executed next cycle");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

>>> hw/rtl/rdq_datapath.sv
// pointers, count, orientation flag and entry store of the reversible deque
module rdq_datapath
    import rdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctl_t      ctl,
    input  in_word_t  item,
    output sts_t      sts,
    output out_word_t result
);

    // latched command word
    logic [2:0]        cmd_reg;
    logic [DATA_W-1:0] value_reg;

    // deque state
    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rev_reg;
    logic              rev_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;

    // store
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // decode
    logic              is_push;
    logic              is_pop;
    logic              is_rev;
    logic              at_back;
    logic              full;
    logic              empty;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  last_sum;
    logic [ADDR_W-1:0] tail_addr;
    logic [ADDR_W-1:0] last_addr;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_re;

    // latch the accepted word
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= item.command;
            value_reg <= item.value;
        end
    end

    // command decode and end selection
    always_comb
    begin
        is_push = cmd_reg inside {CMD_PUSH_BACK, CMD_PUSH_FRONT};
        is_pop  = cmd_reg inside {CMD_POP_BACK, CMD_POP_FRONT};
        is_rev  = (cmd_reg == CMD_REVERSE);
        at_back = (cmd_reg inside {CMD_PUSH_BACK, CMD_POP_BACK}) ^ rev_reg;
        full    = (count_reg == CNT_W'(DEPTH));
        empty   = (count_reg == '0);
    end

    // circular address arithmetic, one compare and one add or subtract each
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        last_sum = tail_sum - SUM_W'(1);
        if (tail_sum >= SUM_W'(DEPTH))
        begin
            tail_addr = ADDR_W'(tail_sum - SUM_W'(DEPTH));
        end
        else
        begin
            tail_addr = ADDR_W'(tail_sum);
        end
        if (last_sum >= SUM_W'(DEPTH))
        begin
            last_addr = ADDR_W'(last_sum - SUM_W'(DEPTH));
        end
        else
        begin
            last_addr = ADDR_W'(last_sum);
        end
        if (head_reg == '0)
        begin
            head_dec = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            head_dec = head_reg - ADDR_W'(1);
        end
        if (head_reg == ADDR_W'(DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + ADDR_W'(1);
        end
    end

    // execute step: store access and state update
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = head_reg;
        sts.has_result = 1'b0;
        if (ctl.exec)
        begin
            if (is_rev)
            begin
                rev_next = !rev_reg;
            end
            else if (is_push)
            begin
                if (full)
                begin
                    status_next    = ST_FULL;
                    sts.has_result = 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (at_back)
                    begin
                        mem_addr = tail_addr;
                    end
                    else
                    begin
                        mem_addr  = head_dec;
                        head_next = head_dec;
                    end
                end
            end
            else if (is_pop)
            begin
                sts.has_result = 1'b1;
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_POPPED;
                    mem_re      = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                    if (at_back)
                    begin
                        mem_addr = last_addr;
                    end
                    else
                    begin
                        mem_addr  = head_reg;
                        head_next = head_inc;
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    // result status
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    // entry store, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= value_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // result word
    assign result.status       = status_reg;
    assign result.popped_value = (status_reg == ST_POPPED) ? rdata_reg : '0;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond store depth");
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= ADDR_W'(DEPTH - 1))
        else $error("head pointer outside store");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec && is_pop && !empty |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not decrement count");
    a_rev_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec && is_rev |=> rev_reg != $past(rev_reg))
        else $error("reverse did not toggle orientation");

endmodule

>>> hw/rtl/reversible_deque.sv
// Reversible deque: a double-ended queue of 32-bit words in a circular store
// with a constant-time reverse command.
//
// Input channel: an input word (command, value) is taken at a rising edge
// where start is high and busy is low. Commands are push back, push front,
// pop back, pop front and reverse; unknown codes are ignored.
// Result channel: done is high for exactly one cycle with the result word
// (status, popped_value); the receiver cannot stall and must take it then.
// A pop always gives a result (popped word or empty status); a push into a
// full store gives a full status and is dropped; other commands give none.
// Timing: the word is executed in the cycle after it is taken; a word without
// a result ends there. For a result, status and popped value are registered in
// the execute step and go out in the response state, as the single-port store's
// read data is registered. Busy stays high until the word is done.
// Reset: head, count and orientation clear at once, the store contents are
// left as they are; a word in flight is lost; the block is ready right after reset.
module reversible_deque
    import rdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  item,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

    ctl_t ctl;
    sts_t sts;

    // sequencer
    rdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // storage and pointer logic
    rdq_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (item),
        .sts    (sts),
        .result (result)
    );

endmodule
